// ===== hdl/skv_pkg.sv =====
// Shared types, codes and result builders for the section/key/value tokenizer.
`timescale 1ns / 1ps

package skv_pkg;

  // parser states
  typedef enum logic [2:0] {
    ST_START   = 3'd0,
    ST_TBEFORE = 3'd1,
    ST_TITLE   = 3'd2,
    ST_TAFTER  = 3'd3,
    ST_KEY     = 3'd4,
    ST_VALUE   = 3'd5,
    ST_NEWLINE = 3'd6,
    ST_SPACE   = 3'd7
  } st_t;

  // result kinds
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // token kinds
  localparam logic [1:0] TOK_TITLE0 = 2'd0;
  localparam logic [1:0] TOK_TITLE1 = 2'd1;
  localparam logic [1:0] TOK_KEY    = 2'd2;
  localparam logic [1:0] TOK_VALUE  = 2'd3;

  // error codes
  localparam logic [1:0] ERR_WS_BEFORE_TITLE = 2'd0;
  localparam logic [1:0] ERR_BAD_AFTER_TITLE = 2'd1;
  localparam logic [1:0] ERR_BLANK_LINE      = 2'd2;
  localparam logic [1:0] ERR_INCOMPLETE      = 2'd3;

  // characters
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [1:0] tk;
    logic [1:0] ec;
  } res_t;

  // up to two results from one item
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } step_out_t;

  function automatic res_t mk_char(input logic [7:0] c);
    res_t r;
    r      = '0;
    r.kind = KIND_CHAR;
    r.ch   = c;
    return r;
  endfunction

  function automatic res_t mk_end(input logic [1:0] t);
    res_t r;
    r      = '0;
    r.kind = KIND_END;
    r.tk   = t;
    return r;
  endfunction

  function automatic res_t mk_err(input logic [1:0] e);
    res_t r;
    r      = '0;
    r.kind = KIND_ERR;
    r.ec   = e;
    return r;
  endfunction

endpackage

// ===== hdl/skv_parser.sv =====
// Tokenizer state registers and per-byte next-state / result logic.
`timescale 1ns / 1ps

module skv_parser import skv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic [7:0] byte_value,
  input  logic      stream_done,
  output step_out_t so
);

  st_t  ps_r, ps_nxt;
  st_t  rs_r, rs_nxt;
  logic minus_r, minus_nxt;
  logic has_text_r, has_text_nxt;
  logic halted_r, halted_nxt;

  logic [7:0] trig;
  logic       ws;
  logic       nl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r       <= ST_START;
      rs_r       <= ST_START;
      minus_r    <= 1'b0;
      has_text_r <= 1'b0;
      halted_r   <= 1'b0;
    end else if (adv) begin
      ps_r       <= ps_nxt;
      rs_r       <= rs_nxt;
      minus_r    <= minus_nxt;
      has_text_r <= has_text_nxt;
      halted_r   <= halted_nxt;
    end
  end

  assign trig = minus_r ? CH_MINUS : CH_EQ;
  assign ws   = (byte_value <= CH_SPACE);
  assign nl   = (byte_value == CH_LF);

  always_comb begin
    ps_nxt       = ps_r;
    rs_nxt       = rs_r;
    minus_nxt    = minus_r;
    has_text_nxt = has_text_r;
    halted_nxt   = halted_r;
    so           = '0;

    if (stream_done) begin
      if (!halted_r) begin
        if (ps_r == ST_VALUE || rs_r == ST_VALUE) begin
          so.n  = 2'd1;
          so.r0 = mk_end(TOK_VALUE);
        end else if (ps_r != ST_START) begin
          so.n  = 2'd1;
          so.r0 = mk_err(ERR_INCOMPLETE);
        end
      end
      ps_nxt       = ST_START;
      rs_nxt       = ST_START;
      minus_nxt    = 1'b0;
      has_text_nxt = 1'b0;
      halted_nxt   = 1'b0;
    end else if (!halted_r && byte_value != CH_CR) begin
      unique case (ps_r)
        ST_START: begin
          if (byte_value == CH_EQ || byte_value == CH_MINUS) begin
            minus_nxt = (byte_value == CH_MINUS);
            ps_nxt    = ST_TBEFORE;
          end else if (!ws) begin
            so.n         = 2'd1;
            so.r0        = mk_char(byte_value);
            has_text_nxt = 1'b1;
            ps_nxt       = ST_KEY;
          end
        end
        ST_SPACE: begin
          if (nl) begin
            ps_nxt = ST_NEWLINE;
          end else if (!ws) begin
            ps_nxt       = rs_r;
            has_text_nxt = 1'b1;
            if (has_text_r) begin
              so.n  = 2'd2;
              so.r0 = mk_char(CH_SPACE);
              so.r1 = mk_char(byte_value);
            end else begin
              so.n  = 2'd1;
              so.r0 = mk_char(byte_value);
            end
          end
        end
        ST_TBEFORE: begin
          if (ws) begin
            so.n       = 2'd1;
            so.r0      = mk_err(ERR_WS_BEFORE_TITLE);
            halted_nxt = 1'b1;
          end else if (byte_value != trig) begin
            so.n         = 2'd1;
            so.r0        = mk_char(byte_value);
            has_text_nxt = 1'b1;
            ps_nxt       = ST_TITLE;
          end
        end
        ST_TITLE: begin
          if (ws) begin
            rs_nxt = ST_TITLE;
            ps_nxt = nl ? ST_NEWLINE : ST_SPACE;
          end else if (byte_value == trig) begin
            ps_nxt = ST_TAFTER;
          end else begin
            so.n         = 2'd1;
            so.r0        = mk_char(byte_value);
            has_text_nxt = 1'b1;
          end
        end
        ST_TAFTER: begin
          if (nl) begin
            so.n         = 2'd1;
            so.r0        = mk_end(minus_r ? TOK_TITLE1 : TOK_TITLE0);
            ps_nxt       = ST_START;
            rs_nxt       = ST_START;
            has_text_nxt = 1'b0;
          end else if (byte_value != trig) begin
            so.n       = 2'd1;
            so.r0      = mk_err(ERR_BAD_AFTER_TITLE);
            halted_nxt = 1'b1;
          end
        end
        ST_KEY, ST_VALUE: begin
          if (ps_r == ST_KEY && byte_value == CH_COLON) begin
            so.n         = 2'd1;
            so.r0        = mk_end(TOK_KEY);
            ps_nxt       = ST_VALUE;
            rs_nxt       = ST_START;
            has_text_nxt = 1'b0;
          end else if (ws) begin
            rs_nxt = ps_r;
            ps_nxt = nl ? ST_NEWLINE : ST_SPACE;
          end else begin
            so.n         = 2'd1;
            so.r0        = mk_char(byte_value);
            has_text_nxt = 1'b1;
          end
        end
        ST_NEWLINE: begin
          if (nl) begin
            so.n = 2'd1;
            if (rs_r != ST_VALUE) begin
              so.r0      = mk_err(ERR_BLANK_LINE);
              halted_nxt = 1'b1;
            end else begin
              so.r0        = mk_end(TOK_VALUE);
              ps_nxt       = ST_START;
              rs_nxt       = ST_START;
              has_text_nxt = 1'b0;
            end
          end else if (!ws) begin
            // a line break always yields a space, even before any text
            so.n         = 2'd2;
            so.r0        = mk_char(CH_SPACE);
            so.r1        = mk_char(byte_value);
            has_text_nxt = 1'b1;
            ps_nxt       = rs_r;
          end
        end
        default: begin
          ps_nxt = ps_r;
        end
      endcase
    end
  end

endmodule

// ===== hdl/skv_out_buf.sv =====
// Two-entry result register that drains the results of one item in order.
`timescale 1ns / 1ps

module skv_out_buf import skv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  step_out_t  so,
  output logic       free,
  output logic       out_valid,
  input  logic       out_stall,
  output res_t       head,
  output logic       last
);

  logic [1:0] cnt_r, cnt_nxt;
  logic       sel_r, sel_nxt;
  res_t       r0_r, r1_r;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign free      = (cnt_r == 2'd0) || (cnt_r == 2'd1 && !out_stall);
  assign head      = sel_r ? r1_r : r0_r;
  assign last      = (cnt_r == 2'd1);

  always_comb begin
    cnt_nxt = cnt_r;
    sel_nxt = sel_r;
    if (load) begin
      cnt_nxt = so.n;
      sel_nxt = 1'b0;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
      sel_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      sel_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      sel_r <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      r0_r <= so.r0;
      r1_r <= so.r1;
    end
  end

endmodule

// ===== hdl/section_key_value_tokenizer.sv =====
// Top level of the section/key/value tokenizer: input register, parser, result register.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | byte_value[7:0], stream_done
//  out_    | output    | out_valid/out_stall | result_kind, text_char, token_kind,
//          |           |                     | error_code, last_of_run
//
// A byte with at most one result frees the buffer as that result leaves; a space plus a
// character holds the next byte until the single result port drains the first entry.
// Each result passes the input register and then the result register.
// Reset (synchronous, rst_n low) returns the parser to the start of a token.
// out_stall holds the result register; the input register then fills and in_stall rises.
`timescale 1ns / 1ps

module section_key_value_tokenizer import skv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_value,
  input  logic       in_stream_done,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_text_char,
  output logic [1:0] out_token_kind,
  output logic [1:0] out_error_code,
  output logic       out_last_of_run
);

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] byte_r;
  logic       done_r;
  logic       accept;
  logic       adv;
  logic       buf_free;
  step_out_t  so;
  res_t       head;

  assign adv      = in_vld_r && buf_free;
  assign in_stall = in_vld_r && !buf_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte_value;
      done_r <= in_stream_done;
    end
  end

  skv_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .byte_value  (byte_r),
    .stream_done (done_r),
    .so          (so)
  );

  skv_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .so        (so),
    .free      (buf_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head),
    .last      (out_last_of_run)
  );

  assign out_result_kind = head.kind;
  assign out_text_char   = head.ch;
  assign out_token_kind  = head.tk;
  assign out_error_code  = head.ec;

endmodule
